// ===== rtl/core/rci_pkg.sv =====
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types and codes for the segment/circle intersection pipeline.
// ----------------------------------------------------------------------------
package rci_pkg;

  localparam int COORD_WIDTH = 32;

  // result status codes
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic                          want_near_root;
  } req_t;

  typedef struct packed {
    logic [1:0]                    hit_status;
    logic signed [COORD_WIDTH-1:0] hit_param;
  } rsp_t;

endpackage

// ===== rtl/core/ray_circle_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_circle_intersection
// Segment versus circle intersection in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Circle center and radius are written on the cfg channel (cfg_valid and
//   cfg_ready, cfg_index selects center_x, center_y or radius). cfg_ready is
//   always high; write only while no query is in flight.
//   A query is a transaction on start while busy is low; busy never rises, so
//   one query can enter on every clock.
//   Each query yields one result, shown on result for exactly one cycle with
//   result_valid. Results come back in query order.
//   The pipeline runs through two levels of 4-stage multipliers, a square root
//   at one bit per stage and a divider at one quotient bit per stage.
//   Throughput is one query per cycle.
//   Reset flushes all in-flight queries and sets the center to the origin
//   and the radius to 1.0. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module ray_circle_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  rci_pkg::req_t                       request,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [rci_pkg::COORD_WIDTH-1:0]     cfg_data,
  output logic                                result_valid,
  output rci_pkg::rsp_t                       result
);

  localparam int CW  = rci_pkg::COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int AW  = 2 * DW + 1;
  localparam int DSW = 2 * AW + 1;
  localparam int IW  = DSW - 1;
  localparam int OW  = (IW + 1) / 2;
  localparam int NUW = AW + 2;
  localparam int MW  = NUW + FRAC_BITS;
  localparam int BW  = AW - 1;
  localparam int QW  = MW + 2;
  localparam int SB2 = 1 + 2 * AW;
  localparam int SB3 = SB2 + 2;
  localparam logic signed [CW-1:0] MISS_T = CW'(-(64'sd1 <<< FRAC_BITS));

  // configuration
  logic signed [CW-1:0] center_x, center_y;
  logic [CW-2:0]        radius;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= (CW-1)'(1) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rci_pkg::REG_CENTER_X: center_x <= cfg_data;
        rci_pkg::REG_CENTER_Y: center_y <= cfg_data;
        rci_pkg::REG_RADIUS:   radius   <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // stage 1: deltas
  logic                 accept, v1, near1;
  logic signed [DW-1:0] dlx1, dly1, ddx1, ddy1, rad1;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    near1 <= request.want_near_root;
    dlx1  <= DW'(request.start_x) - DW'(center_x);
    dly1  <= DW'(request.start_y) - DW'(center_y);
    ddx1  <= DW'(request.end_x) - DW'(request.start_x);
    ddy1  <= DW'(request.end_y) - DW'(request.start_y);
    rad1  <= signed'({2'b00, radius});
  end

  // first products
  logic signed [2*DW-1:0] p_ax, p_ay, p_bx, p_by, p_cx, p_cy, p_rr;
  logic                   v2, near2;

  rci_mul #(.W(DW), .SBW(1)) u_mul_ax (
    .clk, .rst, .in_valid(v1), .a(ddx1), .b(dlx1), .sb_in(near1),
    .out_valid(v2), .p(p_ax), .sb_out(near2));
  rci_mul #(.W(DW), .SBW(1)) u_mul_ay (
    .clk, .rst, .in_valid(v1), .a(ddy1), .b(dly1), .sb_in(1'b0),
    .out_valid(), .p(p_ay), .sb_out());
  rci_mul #(.W(DW), .SBW(1)) u_mul_bx (
    .clk, .rst, .in_valid(v1), .a(ddx1), .b(ddx1), .sb_in(1'b0),
    .out_valid(), .p(p_bx), .sb_out());
  rci_mul #(.W(DW), .SBW(1)) u_mul_by (
    .clk, .rst, .in_valid(v1), .a(ddy1), .b(ddy1), .sb_in(1'b0),
    .out_valid(), .p(p_by), .sb_out());
  rci_mul #(.W(DW), .SBW(1)) u_mul_cx (
    .clk, .rst, .in_valid(v1), .a(dlx1), .b(dlx1), .sb_in(1'b0),
    .out_valid(), .p(p_cx), .sb_out());
  rci_mul #(.W(DW), .SBW(1)) u_mul_cy (
    .clk, .rst, .in_valid(v1), .a(dly1), .b(dly1), .sb_in(1'b0),
    .out_valid(), .p(p_cy), .sb_out());
  rci_mul #(.W(DW), .SBW(1)) u_mul_rr (
    .clk, .rst, .in_valid(v1), .a(rad1), .b(rad1), .sb_in(1'b0),
    .out_valid(), .p(p_rr), .sb_out());

  // stage 3: a, b, c - r^2
  logic                 v3, near3;
  logic signed [AW-1:0] a3, b3, cmr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    near3 <= near2;
    a3    <= AW'(p_ax) + AW'(p_ay);
    b3    <= AW'(p_bx) + AW'(p_by);
    cmr3  <= AW'(p_cx) + AW'(p_cy) - AW'(p_rr);
  end

  // second products: a^2 and b*(c - r^2)
  logic signed [2*AW-1:0] aa, bc;
  logic                   v4;
  logic [SB2-1:0]         sb4;

  rci_mul #(.W(AW), .SBW(SB2)) u_mul_aa (
    .clk, .rst, .in_valid(v3), .a(a3), .b(a3), .sb_in({near3, a3, b3}),
    .out_valid(v4), .p(aa), .sb_out(sb4));
  rci_mul #(.W(AW), .SBW(1)) u_mul_bc (
    .clk, .rst, .in_valid(v3), .a(b3), .b(cmr3), .sb_in(1'b0),
    .out_valid(), .p(bc), .sb_out());

  // stage 5: discriminant
  logic                  v5;
  logic signed [DSW-1:0] disc5;
  logic [SB2-1:0]        sb5;
  logic [AW-1:0]         b5;
  logic                  miss5;
  logic [1:0]            st5;
  logic [IW-1:0]         sq_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    sb5   <= sb4;
    disc5 <= DSW'(aa) - DSW'(bc);
  end

  assign b5    = sb5[AW-1:0];
  assign miss5 = disc5[DSW-1];
  assign sq_in = miss5 ? '0 : disc5[IW-1:0];

  always_comb begin
    priority if (b5 == '0) begin
      st5 = rci_pkg::ST_DEGEN;
    end else if (miss5) begin
      st5 = rci_pkg::ST_MISS;
    end else begin
      st5 = rci_pkg::ST_HIT;
    end
  end

  // square root
  logic [OW-1:0]  s_root;
  logic           v6;
  logic [SB3-1:0] sb6;
  logic           near6;
  logic [AW-1:0]  a6, b6;
  logic [1:0]     st6;

  rci_sqrt #(.IW(IW), .SBW(SB3)) u_sqrt (
    .clk, .rst, .in_valid(v5), .n(sq_in), .sb_in({sb5, st5}),
    .out_valid(v6), .root(s_root), .sb_out(sb6));

  assign {near6, a6, b6, st6} = sb6;

  // stage 7: numerator -a +/- s
  logic                  v7;
  logic signed [NUW-1:0] num7;
  logic [BW-1:0]         b7;
  logic [1:0]            st7;
  logic [NUW-1:0]        neg_a6, s_ext6;

  assign neg_a6 = -NUW'(signed'(a6));
  assign s_ext6 = NUW'(s_root);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    num7 <= near6 ? signed'(neg_a6 - s_ext6) : signed'(neg_a6 + s_ext6);
    b7   <= b6[BW-1:0];
    st7  <= st6;
  end

  // stage 8: sign and scaled magnitude
  logic           v8, neg8;
  logic [MW-1:0]  mag8;
  logic [BW-1:0]  b8;
  logic [1:0]     st8;
  logic [NUW-1:0] abs7;

  assign abs7 = num7[NUW-1] ? NUW'(-num7) : NUW'(num7);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    neg8 <= num7[NUW-1];
    mag8 <= MW'(abs7) << FRAC_BITS;
    b8   <= b7;
    st8  <= st7;
  end

  // division
  logic [MW-1:0] quo;
  logic          rem_nz, vq, negq;
  logic [1:0]    stq;

  rci_div #(.NW(MW), .DVW(BW), .SBW(3)) u_div (
    .clk, .rst, .in_valid(v8), .n(mag8), .d(b8), .sb_in({neg8, st8}),
    .out_valid(vq), .q(quo), .rem_nz, .sb_out({negq, stq}));

  // stage 9: floor toward minus infinity
  logic                 v9;
  logic signed [QW-1:0] qs9;
  logic [1:0]           st9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= vq;
    end
    qs9 <= negq ? -signed'(QW'(quo) + QW'(rem_nz)) : signed'(QW'(quo));
    st9 <= stq;
  end

  // output: saturate and select by status
  logic                 fits;
  logic signed [CW-1:0] sat9, param9;

  assign fits = (&qs9[QW-1:CW-1]) || !(|qs9[QW-1:CW-1]);
  assign sat9 = fits ? qs9[CW-1:0]
              : (qs9[QW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

  always_comb begin
    unique case (st9)
      rci_pkg::ST_HIT:   param9 = sat9;
      rci_pkg::ST_MISS:  param9 = MISS_T;
      rci_pkg::ST_DEGEN: param9 = '0;
      default:           param9 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v9;
    end
    result.hit_status <= st9;
    result.hit_param  <= param9;
  end

  // checks
  a_miss_param: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit_status == rci_pkg::ST_MISS |-> result.hit_param == MISS_T)
    else $error("miss result carries wrong parameter");

  a_degen_param: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit_status == rci_pkg::ST_DEGEN |-> result.hit_param == '0)
    else $error("degenerate result carries nonzero parameter");

  a_sat_sign: assert property (@(posedge clk) disable iff (rst)
    v9 && st9 == rci_pkg::ST_HIT && !fits |=> result.hit_param[CW-1] == $past(qs9[QW-1]))
    else $error("saturation picked the wrong limit");

endmodule

// ===== rtl/core/rci_mul.sv =====
// ----------------------------------------------------------------------------
// rci_mul
// Four-stage signed multiplier built from registered 34x34 partial products.
// ----------------------------------------------------------------------------
module rci_mul #(
  parameter int W   = 33,
  parameter int SBW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  input  logic [SBW-1:0]        sb_in,
  output logic                  out_valid,
  output logic signed [2*W-1:0] p,
  output logic [SBW-1:0]        sb_out
);

  localparam int DG = 34;
  localparam int K  = (W + DG - 1) / DG;
  localparam int XW = K * DG;

  logic [W-1:0]      ua, ub;
  logic [XW-1:0]     mag_a, mag_b;
  logic [2*DG-1:0]   pp [K*K];
  logic [2*XW-1:0]   sum_c;
  logic [2*W-1:0]    sum3;
  logic              neg1, neg2, neg3;
  logic [3:0]        vld;
  logic [SBW-1:0]    sbp [4];

  assign ua = a[W-1] ? W'(-a) : W'(a);
  assign ub = b[W-1] ? W'(-b) : W'(b);

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        sum_c = sum_c + ((2*XW)'(pp[i*K+j]) << (DG*(i+j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
    sbp[0] <= sb_in;
    sbp[1] <= sbp[0];
    sbp[2] <= sbp[1];
    sbp[3] <= sbp[2];
    mag_a  <= XW'(ua);
    mag_b  <= XW'(ub);
    neg1   <= a[W-1] ^ b[W-1];
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        pp[i*K+j] <= mag_a[i*DG +: DG] * mag_b[j*DG +: DG];
      end
    end
    neg2 <= neg1;
    sum3 <= sum_c[2*W-1:0];
    neg3 <= neg2;
    p    <= neg3 ? -signed'(sum3) : signed'(sum3);
  end

  assign out_valid = vld[3];
  assign sb_out    = sbp[3];

endmodule

// ===== rtl/core/rci_sqrt.sv =====
// ----------------------------------------------------------------------------
// rci_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rci_sqrt #(
  parameter int IW  = 134,
  parameter int SBW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [IW-1:0]               n,
  input  logic [SBW-1:0]              sb_in,
  output logic                        out_valid,
  output logic [(IW+1)/2-1:0]         root,
  output logic [SBW-1:0]              sb_out
);

  localparam int OW = (IW + 1) / 2;
  localparam int PW = 2 * OW;
  localparam int RW = OW + 2;

  logic [PW-1:0]  nr [1:OW];
  logic [RW-1:0]  rm [1:OW];
  logic [OW-1:0]  rt [1:OW];
  logic           vl [1:OW];
  logic [SBW-1:0] sb [1:OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [PW-1:0]  n_i;
    logic [RW-1:0]  r_i;
    logic [OW-1:0]  q_i;
    logic           v_i;
    logic [SBW-1:0] s_i;
    logic [RW-1:0]  cur, trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign n_i = PW'(n);
      assign r_i = '0;
      assign q_i = '0;
      assign v_i = in_valid;
      assign s_i = sb_in;
    end else begin : g_rest
      assign n_i = nr[k];
      assign r_i = rm[k];
      assign q_i = rt[k];
      assign v_i = vl[k];
      assign s_i = sb[k];
    end

    assign cur   = {r_i[RW-3:0], n_i[PW-1 -: 2]};
    assign trial = {q_i, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else begin
        vl[k+1] <= v_i;
      end
      sb[k+1] <= s_i;
      nr[k+1] <= n_i << 2;
      rm[k+1] <= ge ? cur - trial : cur;
      rt[k+1] <= {q_i[OW-2:0], ge};
    end
  end

  assign out_valid = vl[OW];
  assign root      = rt[OW];
  assign sb_out    = sb[OW];

endmodule

// ===== rtl/core/rci_div.sv =====
// ----------------------------------------------------------------------------
// rci_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rci_div #(
  parameter int NW  = 85,
  parameter int DVW = 66,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [NW-1:0]  n,
  input  logic [DVW-1:0] d,
  input  logic [SBW-1:0] sb_in,
  output logic           out_valid,
  output logic [NW-1:0]  q,
  output logic           rem_nz,
  output logic [SBW-1:0] sb_out
);

  // nq holds the remaining dividend bits on top, quotient bits shift in below
  logic [NW-1:0]  nq [1:NW];
  logic [DVW-1:0] rm [1:NW];
  logic [DVW-1:0] dv [1:NW];
  logic           vl [1:NW];
  logic [SBW-1:0] sb [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0]  nq_i;
    logic [DVW-1:0] r_i, d_i;
    logic           v_i;
    logic [SBW-1:0] s_i;
    logic [DVW:0]   cur, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign nq_i = n;
      assign r_i  = '0;
      assign d_i  = d;
      assign v_i  = in_valid;
      assign s_i  = sb_in;
    end else begin : g_rest
      assign nq_i = nq[k];
      assign r_i  = rm[k];
      assign d_i  = dv[k];
      assign v_i  = vl[k];
      assign s_i  = sb[k];
    end

    assign cur  = {r_i, nq_i[NW-1]};
    assign diff = cur - {1'b0, d_i};
    assign ge   = cur >= {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else begin
        vl[k+1] <= v_i;
      end
      sb[k+1] <= s_i;
      dv[k+1] <= d_i;
      nq[k+1] <= {nq_i[NW-2:0], ge};
      rm[k+1] <= ge ? diff[DVW-1:0] : cur[DVW-1:0];
    end
  end

  assign out_valid = vl[NW];
  assign q         = nq[NW];
  assign rem_nz    = |rm[NW];
  assign sb_out    = sb[NW];

endmodule
